### sv/twr_ranging_table_engine_assert.svh
// assertion macros shared by the ranging engine modules
`ifndef TWR_RANGING_TABLE_ENGINE_ASSERT_SVH
`define TWR_RANGING_TABLE_ENGINE_ASSERT_SVH

// same-cycle implication
`define TWR_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("twr assertion failed");

// next-cycle implication
`define TWR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("twr assertion failed");

`endif

### sv/twr_pkg.sv
package twr_pkg;

	localparam logic [1:0] CMD_HEADER  = 2'd0;
	localparam logic [1:0] CMD_BODY    = 2'd1;
	localparam logic [1:0] CMD_TX_DONE = 2'd2;

	localparam logic [1:0] STS_UPDATED = 2'd0;
	localparam logic [1:0] STS_DIST    = 2'd1;
	localparam logic [1:0] STS_FULL    = 2'd2;
	localparam logic [1:0] STS_ZERO    = 2'd3;

	// quotient magnitude clamp is 2^MAG_BITS
	localparam int MAG_BITS = 17;
	// cm per tick, q0.32
	localparam logic [30:0] SCALE_Q32 = 31'd2015097285;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} arith_op_t;

	typedef struct packed {
		logic      start;
		arith_op_t op;
	} arith_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} arith_sts_t;

endpackage

### sv/twr_if.sv
interface twr_msg_if #(parameter int STAMP_BITS = 40) ();
	logic                  valid;
	logic                  ready;
	logic [1:0]            command;
	logic                  last_of_message;
	logic [15:0]           peer_address;
	logic [STAMP_BITS-1:0] stamp;
	logic [15:0]           stamp_sequence;
	logic [15:0]           echo_sequence;
	logic [STAMP_BITS-1:0] echo_stamp;

	modport source (output valid, command, last_of_message, peer_address, stamp,
		stamp_sequence, echo_sequence, echo_stamp, input ready);
	modport sink (input valid, command, last_of_message, peer_address, stamp,
		stamp_sequence, echo_sequence, echo_stamp, output ready);
endinterface

interface twr_res_if ();
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [15:0] distance_cm;
	logic [3:0]         table_slot;

	modport source (output valid, status, distance_cm, table_slot, input ready);
	modport sink (input valid, status, distance_cm, table_slot, output ready);
endinterface

interface twr_cfg_if ();
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### sv/twr_ranging_table_engine.sv
// channel | dir | handshake   | carries
// msg     | in  | valid/ready | command, last flag, peer address, stamps, sequences
// res     | out | valid/ready | status, distance_cm, table_slot
// cfg     | in  | valid/ready | my_address write data (always ready)
//
// transmit-done, non-closing header and body items are handled in idle, msg stays ready
// a closing item walks the table entry by entry and, with a reply stamp, the transmit
// ring slot by slot; a distance adds two serial multiplies and a serial divide on
// the one shared unit; msg is not ready until res takes it
// arst_n clears entry valid bits, ring valid bits, ring position and the open message
`include "twr_ranging_table_engine_assert.svh"

module twr_ranging_table_engine #(
	parameter int TABLE_ENTRIES  = 16,
	parameter int TX_STAMP_SLOTS = 8,
	parameter int STAMP_BITS     = 40
) (
	input  logic      clk,
	input  logic      arst_n,
	twr_msg_if.sink   msg,
	twr_res_if.source res,
	twr_cfg_if.sink   cfg
);
	import twr_pkg::*;

	localparam int W  = STAMP_BITS;
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int RW = (TX_STAMP_SLOTS > 1) ? $clog2(TX_STAMP_SLOTS) : 1;

	typedef struct packed {
		logic [W-1:0] t;
		logic [15:0]  s;
	} tup_t;

	typedef struct packed {
		logic [15:0] addr;
		tup_t        rp;
		tup_t        tp;
		tup_t        rr;
		tup_t        tr;
		tup_t        rf;
		tup_t        tf;
		tup_t        re;
	} entry_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CHK,
		ST_UPD,
		ST_RING_RD,
		ST_RING_CHK,
		ST_CHECK,
		ST_DIFF,
		ST_SUM,
		ST_SUM2,
		ST_MUL1,
		ST_MUL1_W,
		ST_MUL2,
		ST_MUL2_W,
		ST_SUBP,
		ST_ABS,
		ST_DIV,
		ST_DIV_W,
		ST_SCALE,
		ST_FIN,
		ST_ROT,
		ST_WB,
		ST_OUT
	} state_t;

	state_t state_q;

	// configuration and open-message registers
	logic [15:0]         my_addr_q;
	logic                open_q;
	logic [15:0]         hdr_peer_q;
	logic [W-1:0]        hdr_rx_q;
	logic [15:0]         hdr_seq_q;
	logic [15:0]         hdr_echo_seq_q;
	logic [W-1:0]        hdr_echo_t_q;
	logic                rep_found_q;
	logic [W-1:0]        rep_t_q;
	logic [15:0]         rep_s_q;

	// table, ring and walk control
	logic [TABLE_ENTRIES-1:0]  ent_vld_q;
	logic [TX_STAMP_SLOTS-1:0] ring_vld_q;
	logic [RW-1:0]             pos_q;
	logic [RW-1:0]             pos_nx;
	logic [IW-1:0]             idx_q;
	logic [IW-1:0]             free_q;
	logic                      free_ok_q;
	logic [IW-1:0]             free_sel;
	logic [IW-1:0]             e_q;
	logic [RW-1:0]             rix_q;
	logic                      ring_vld_rd_q;
	entry_t                    ent_q;

	// distance datapath
	logic [W-1:0]        ra_q, rb_q, da_q, db_q;
	logic [W:0]          s1_q, s2_q;
	logic [W+1:0]        d_q;
	logic [2*W-1:0]      p1_q, p2_q;
	logic [2*W-1:0]      nd_q;
	logic                nb_q;
	logic [2*W-1:0]      n_q;
	logic                neg_q;
	logic [MAG_BITS:0]   mag_q;
	logic [MAG_BITS-1:0] scaled_q;
	logic [48:0]         sc_full;

	// result registers
	logic [1:0]          status_q;
	logic signed [15:0]  dist_q;
	logic [3:0]          slot_q;

	// memories
	entry_t              tbl_mem [TABLE_ENTRIES];
	entry_t              tbl_rd_q;
	tup_t                ring_mem [TX_STAMP_SLOTS];
	tup_t                ring_rd_q;
	tup_t                ring_data;

	// shared arithmetic unit
	arith_ctl_t          a_ctl;
	arith_sts_t          a_sts;
	logic [2*W-1:0]      a_opa;
	logic [W+1:0]        a_opb;
	logic [2*W-1:0]      a_prod;
	logic [MAG_BITS:0]   a_mag;

	logic                msg_acc;
	logic                tx_acc;

	twr_arith #(.W(W)) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (a_ctl),
		.opa    (a_opa),
		.opb    (a_opb),
		.sts    (a_sts),
		.prod   (a_prod),
		.mag    (a_mag)
	);

	assign msg.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign msg_acc   = msg.valid && msg.ready;
	assign tx_acc    = msg_acc && (msg.command == CMD_TX_DONE);

	assign pos_nx    = (pos_q == RW'(TX_STAMP_SLOTS - 1)) ? '0 : pos_q + RW'(1);
	assign free_sel  = free_ok_q ? free_q : idx_q;
	// ring slots never written read as zero
	assign ring_data = ring_vld_rd_q ? ring_rd_q : '0;
	assign sc_full   = 49'(mag_q) * 49'(SCALE_Q32);

	// operand steering for the shared unit
	always_comb begin
		a_ctl = '{start: 1'b0, op: OP_MUL};
		a_opa = {{W{1'b0}}, ra_q};
		a_opb = {2'b00, rb_q};
		case (state_q)
			ST_MUL1: begin
				a_ctl.start = (d_q != '0);
			end
			ST_MUL2: begin
				a_ctl.start = 1'b1;
				a_opa       = {{W{1'b0}}, da_q};
				a_opb       = {2'b00, db_q};
			end
			ST_DIV: begin
				a_ctl = '{start: 1'b1, op: OP_DIV};
				a_opa = n_q;
				a_opb = d_q;
			end
			default: ;
		endcase
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (state_q == ST_WB)
			tbl_mem[e_q] <= ent_q;
		tbl_rd_q <= tbl_mem[idx_q];
	end

	// transmit stamp ring
	always_ff @(posedge clk) begin
		if (tx_acc)
			ring_mem[pos_nx] <= '{t: msg.stamp, s: msg.stamp_sequence};
		ring_rd_q <= ring_mem[rix_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			my_addr_q     <= '0;
			open_q        <= 1'b0;
			rep_found_q   <= 1'b0;
			rep_t_q       <= '0;
			rep_s_q       <= '0;
			ent_vld_q     <= '0;
			ring_vld_q    <= '0;
			ring_vld_rd_q <= 1'b0;
			pos_q         <= '0;
			idx_q         <= '0;
			rix_q         <= '0;
			free_ok_q     <= 1'b0;
			status_q      <= STS_UPDATED;
			dist_q        <= '0;
			slot_q        <= '0;
		end else begin
			if (cfg.valid)
				my_addr_q <= cfg.data;
			ring_vld_rd_q <= ring_vld_q[rix_q];

			case (state_q)
				ST_IDLE: begin
					if (msg_acc) begin
						case (msg.command)
							CMD_HEADER: begin
								// a header that is also last closes at once
								open_q         <= !msg.last_of_message;
								hdr_peer_q     <= msg.peer_address;
								hdr_rx_q       <= msg.stamp;
								hdr_seq_q      <= msg.stamp_sequence;
								hdr_echo_seq_q <= msg.echo_sequence;
								hdr_echo_t_q   <= msg.echo_stamp;
								rep_found_q    <= 1'b0;
								rep_t_q        <= '0;
								rep_s_q        <= '0;
								if (msg.last_of_message) begin
									idx_q     <= '0;
									free_ok_q <= 1'b0;
									status_q  <= STS_UPDATED;
									dist_q    <= '0;
									state_q   <= ST_SRCH_RD;
								end
							end
							CMD_BODY: begin
								if (open_q) begin
									// only the first unit about us counts
									if (!rep_found_q && msg.peer_address == my_addr_q) begin
										rep_found_q <= 1'b1;
										rep_t_q     <= msg.stamp;
										rep_s_q     <= msg.stamp_sequence;
									end
									if (msg.last_of_message) begin
										open_q    <= 1'b0;
										idx_q     <= '0;
										free_ok_q <= 1'b0;
										status_q  <= STS_UPDATED;
										dist_q    <= '0;
										state_q   <= ST_SRCH_RD;
									end
								end
							end
							CMD_TX_DONE: begin
								pos_q              <= pos_nx;
								ring_vld_q[pos_nx] <= 1'b1;
							end
							default: ;
						endcase
					end
				end

				// table walk, sender match first, else first free entry
				ST_SRCH_RD: begin
					state_q <= ST_SRCH_CHK;
				end
				ST_SRCH_CHK: begin
					if (ent_vld_q[idx_q] && tbl_rd_q.addr == hdr_peer_q) begin
						e_q     <= idx_q;
						ent_q   <= tbl_rd_q;
						state_q <= ST_UPD;
					end else begin
						if (!ent_vld_q[idx_q] && !free_ok_q) begin
							free_ok_q <= 1'b1;
							free_q    <= idx_q;
						end
						if (idx_q == IW'(TABLE_ENTRIES - 1)) begin
							if (free_ok_q || !ent_vld_q[idx_q]) begin
								// fresh entry, all stamps cleared
								e_q                 <= free_sel;
								ent_vld_q[free_sel] <= 1'b1;
								ent_q               <= entry_t'({hdr_peer_q,
									{($bits(entry_t) - 16){1'b0}}});
								state_q             <= ST_UPD;
							end else begin
								// table full, message dropped
								status_q <= STS_FULL;
								dist_q   <= '0;
								slot_q   <= '0;
								state_q  <= ST_OUT;
							end
						end else begin
							idx_q   <= idx_q + IW'(1);
							state_q <= ST_SRCH_RD;
						end
					end
				end

				// re, then tr or rr, then rf
				ST_UPD: begin
					ent_q.re <= '{t: hdr_rx_q, s: hdr_seq_q};
					if (ent_q.tr.t == '0) begin
						if (ent_q.rr.s == hdr_echo_seq_q)
							ent_q.tr <= '{t: hdr_echo_t_q, s: hdr_echo_seq_q};
						else
							ent_q.rr <= '{t: hdr_rx_q, s: hdr_seq_q};
					end
					if (rep_found_q && rep_t_q != '0) begin
						ent_q.rf <= '{t: rep_t_q, s: rep_s_q};
						rix_q    <= '0;
						state_q  <= ST_RING_RD;
					end else begin
						state_q <= ST_CHECK;
					end
				end

				// tf lookup, highest matching slot wins
				ST_RING_RD: begin
					state_q <= ST_RING_CHK;
				end
				ST_RING_CHK: begin
					if (ring_data.s == rep_s_q)
						ent_q.tf <= ring_data;
					if (rix_q == RW'(TX_STAMP_SLOTS - 1)) begin
						state_q <= ST_CHECK;
					end else begin
						rix_q   <= rix_q + RW'(1);
						state_q <= ST_RING_RD;
					end
				end

				ST_CHECK: begin
					if (ent_q.tr.t != '0 && ent_q.rf.t != '0 && ent_q.tf.t != '0) begin
						state_q <= ST_DIFF;
					end else if (ent_q.rf.t != '0 && ent_q.tf.t != '0) begin
						// rotate stamps, keep the old sequence numbers
						ent_q.rp   <= ent_q.rf;
						ent_q.tp   <= ent_q.tf;
						ent_q.rr   <= ent_q.re;
						ent_q.rf.t <= '0;
						ent_q.tf.t <= '0;
						ent_q.tr.t <= '0;
						state_q    <= ST_WB;
					end else begin
						state_q <= ST_WB;
					end
				end

				// wrapped round and reply times
				ST_DIFF: begin
					ra_q    <= ent_q.rr.t - ent_q.tp.t;
					db_q    <= ent_q.tr.t - ent_q.rp.t;
					rb_q    <= ent_q.rf.t - ent_q.tr.t;
					da_q    <= ent_q.tf.t - ent_q.rr.t;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					s1_q    <= {1'b0, ra_q} + {1'b0, rb_q};
					s2_q    <= {1'b0, da_q} + {1'b0, db_q};
					state_q <= ST_SUM2;
				end
				ST_SUM2: begin
					d_q     <= {1'b0, s1_q} + {1'b0, s2_q};
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					if (d_q == '0) begin
						status_q <= STS_ZERO;
						dist_q   <= '0;
						state_q  <= ST_ROT;
					end else begin
						state_q <= ST_MUL1_W;
					end
				end
				ST_MUL1_W: begin
					if (a_sts.done) begin
						p1_q    <= a_prod;
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					state_q <= ST_MUL2_W;
				end
				ST_MUL2_W: begin
					if (a_sts.done) begin
						p2_q    <= a_prod;
						state_q <= ST_SUBP;
					end
				end
				ST_SUBP: begin
					{nb_q, nd_q} <= {1'b0, p1_q} - {1'b0, p2_q};
					state_q      <= ST_ABS;
				end
				ST_ABS: begin
					n_q     <= nb_q ? (~nd_q + (2*W)'(1)) : nd_q;
					neg_q   <= nb_q;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					state_q <= ST_DIV_W;
				end
				ST_DIV_W: begin
					if (a_sts.done) begin
						mag_q   <= a_mag;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					scaled_q <= sc_full[48:32];
					state_q  <= ST_FIN;
				end
				// sign and saturate to int16
				ST_FIN: begin
					status_q <= STS_DIST;
					if (neg_q)
						dist_q <= (scaled_q >= 17'd32768) ? 16'sh8000 : 16'(~scaled_q + 17'd1);
					else
						dist_q <= (scaled_q > 17'd32767) ? 16'sh7FFF : 16'(scaled_q);
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					ent_q.rp <= ent_q.rf;
					ent_q.tp <= ent_q.tf;
					ent_q.rr <= ent_q.re;
					ent_q.rf <= '0;
					ent_q.tf <= '0;
					ent_q.tr <= '0;
					state_q  <= ST_WB;
				end
				ST_WB: begin
					slot_q  <= 4'(e_q);
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (res.ready)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid       = (state_q == ST_OUT);
	assign res.status      = status_q;
	assign res.distance_cm = dist_q;
	assign res.table_slot  = slot_q;

	`TWR_ASSERT_NEXT(a_tx_keeps_ready, clk, arst_n, tx_acc, msg.ready)
	`TWR_ASSERT_IMPL(a_full_zero_out, clk, arst_n, res.valid && res.status == STS_FULL, res.table_slot == 4'd0 && res.distance_cm == 16'sd0)
	`TWR_ASSERT_IMPL(a_dist_only_st1, clk, arst_n, res.valid && res.status != STS_DIST, res.distance_cm == 16'sd0)
	`TWR_ASSERT_IMPL(a_entries_kept, clk, arst_n, 1'b1, $countones(ent_vld_q) >= $countones($past(ent_vld_q)))

endmodule

### sv/twr_arith.sv
`include "twr_ranging_table_engine_assert.svh"

module twr_arith #(
	parameter int W = 40
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  twr_pkg::arith_ctl_t         ctl,
	input  logic [2*W-1:0]              opa,
	input  logic [W+1:0]                opb,
	output twr_pkg::arith_sts_t         sts,
	output logic [2*W-1:0]              prod,
	output logic [twr_pkg::MAG_BITS:0]  mag
);
	import twr_pkg::*;

	localparam int AW = W + 3;
	localparam int CW = $clog2(2 * W + 1);

	logic [2*W-1:0]    p_q;
	logic [W+1:0]      x_q;
	logic [W+1:0]      r_q;
	logic [MAG_BITS:0] q_q;
	logic              big_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	arith_op_t         op_q;

	logic [AW-1:0]     add_x;
	logic [AW-1:0]     add_y;
	logic              add_ci;
	logic [AW:0]       add_s;
	logic [AW-1:0]     r_sh;
	logic [MAG_BITS:0] q_nx;

	// one adder: shift-add for multiply, trial subtract for divide
	always_comb begin
		r_sh = {r_q, p_q[2*W-1]};
		if (op_q == OP_MUL) begin
			add_x  = AW'(p_q[2*W-1:W]);
			add_y  = p_q[0] ? AW'(x_q) : '0;
			add_ci = 1'b0;
		end else begin
			add_x  = r_sh;
			add_y  = ~{1'b0, x_q};
			add_ci = 1'b1;
		end
		add_s = {1'b0, add_x} + {1'b0, add_y} + (AW+1)'(add_ci);
		q_nx  = {q_q[MAG_BITS-1:0], add_s[AW]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
			p_q    <= '0;
			x_q    <= '0;
			r_q    <= '0;
			q_q    <= '0;
			big_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				op_q   <= ctl.op;
				r_q    <= '0;
				q_q    <= '0;
				big_q  <= 1'b0;
				if (ctl.op == OP_MUL) begin
					x_q   <= {2'b00, opa[W-1:0]};
					p_q   <= {{W{1'b0}}, opb[W-1:0]};
					cnt_q <= CW'(W);
				end else begin
					x_q   <= opb;
					p_q   <= opa;
					cnt_q <= CW'(2 * W);
				end
			end else if (busy_q) begin
				if (op_q == OP_MUL) begin
					p_q <= {add_s[W:0], p_q[W-1:1]};
				end else begin
					p_q <= {p_q[2*W-2:0], 1'b0};
					r_q <= add_s[AW] ? add_s[W+1:0] : r_sh[W+1:0];
					if (!big_q) begin
						q_q <= q_nx;
						if (q_nx[MAG_BITS])
							big_q <= 1'b1;
					end
				end
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts  = '{busy: busy_q, done: done_q};
	assign prod = p_q;
	assign mag  = big_q ? {1'b1, {MAG_BITS{1'b0}}} : q_q;

	`TWR_ASSERT_IMPL(a_start_when_idle, clk, arst_n, ctl.start, !busy_q)
	`TWR_ASSERT_NEXT(a_last_step_done, clk, arst_n, busy_q && cnt_q == CW'(1), done_q && !busy_q)
	`TWR_ASSERT_IMPL(a_done_not_busy, clk, arst_n, done_q, !busy_q)

endmodule

### dv/twr_ranging_table_engine_test.sv
module twr_ranging_table_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import twr_pkg::*;

	localparam int ENTRIES    = 16;
	localparam int RING_SLOTS = 8;
	localparam int SB         = 40;
	// closing item worst case plus margin, in cycles
	localparam int SETTLE_CYCLES = 400;

	// one stamp with its sequence number
	typedef struct {
		logic [SB-1:0] t;
		logic [15:0]   s;
	} stamp_seq_t;

	// one input item on the message channel
	typedef struct {
		logic [1:0]    command;
		logic          last_of_message;
		logic [15:0]   peer_address;
		logic [SB-1:0] stamp;
		logic [15:0]   stamp_sequence;
		logic [15:0]   echo_sequence;
		logic [SB-1:0] echo_stamp;
	} msg_item_t;

	// one result item
	typedef struct {
		logic [1:0]         status;
		logic signed [15:0] distance_cm;
		logic [3:0]         table_slot;
	} range_result_t;

	logic clk;
	logic arst_n;

	twr_msg_if #(.STAMP_BITS(SB)) msg_ch ();
	twr_res_if res_ch ();
	twr_cfg_if cfg_ch ();

	twr_ranging_table_engine dut (
		.clk   (clk),
		.arst_n(arst_n),
		.msg   (msg_ch),
		.res   (res_ch),
		.cfg   (cfg_ch)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------------------------------------------------------
	// predictor state: neighbor table, transmit ring, open message
	// ---------------------------------------------------------------
	logic [15:0]   own_address;
	bit            nb_valid [ENTRIES];
	logic [15:0]   nb_address [ENTRIES];
	stamp_seq_t    nb_rp [ENTRIES], nb_tp [ENTRIES], nb_rr [ENTRIES], nb_tr [ENTRIES];
	stamp_seq_t    nb_rf [ENTRIES], nb_tf [ENTRIES], nb_re [ENTRIES];
	stamp_seq_t    tx_stamps [RING_SLOTS];
	int            tx_pos;
	bit            msg_open;
	msg_item_t     open_header;
	bit            reply_found;
	stamp_seq_t    reply_stamp;

	// results still owed by the block, oldest first
	range_result_t expected_ranges [$];

	int error_count;

	// traffic knobs, changed by the test sequence
	int send_idle_pct;
	int take_idle_pct;
	int take_hold_cycles;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	// double-sided two-way ranging distance in cm; returns 1 on a zero divisor
	function automatic bit ds_twr_distance(input int e, output logic signed [15:0] range_cm);
		logic [SB-1:0]  ra, db, rb, da;
		logic [SB+1:0]  divisor;
		logic [2*SB-1:0] p_a, p_b, numer, quot;
		logic [63:0]    mag, scaled;
		bit             neg;
		ra = nb_rr[e].t - nb_tp[e].t;
		db = nb_tr[e].t - nb_rp[e].t;
		rb = nb_rf[e].t - nb_tr[e].t;
		da = nb_tf[e].t - nb_rr[e].t;
		divisor = ra + rb + da + db;
		range_cm = '0;
		if (divisor == 0)
			return 1'b1;
		p_a = ra * rb;
		p_b = da * db;
		neg = p_b > p_a;
		numer = neg ? p_b - p_a : p_a - p_b;
		quot = numer / divisor;
		// quotient magnitude is clamped before scaling
		mag = (quot >= (80'd1 << MAG_BITS)) ? (64'd1 << MAG_BITS) : 64'(quot);
		scaled = (mag * 64'(SCALE_Q32)) >> 32;
		if (neg)
			range_cm = (scaled >= 64'd32768) ? 16'sh8000 : -$signed(16'(scaled));
		else
			range_cm = (scaled > 64'd32767) ? 16'sd32767 : $signed(16'(scaled));
		return 1'b0;
	endfunction

	// closes the open message and gives its one result
	function automatic range_result_t close_open_message();
		range_result_t r;
		logic signed [15:0] range_cm;
		int e;
		stamp_seq_t zero_ss;
		zero_ss = '{t: '0, s: '0};
		msg_open = 1'b0;
		r = '{status: STS_UPDATED, distance_cm: '0, table_slot: '0};
		e = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (e < 0 && nb_valid[i] && nb_address[i] == open_header.peer_address)
				e = i;
		if (e < 0) begin
			for (int i = 0; i < ENTRIES; i++)
				if (e < 0 && !nb_valid[i])
					e = i;
			if (e < 0) begin
				r.status = STS_FULL;
				return r;
			end
			// fresh entry starts with all stamps cleared
			nb_valid[e] = 1'b1;
			nb_address[e] = open_header.peer_address;
			nb_rp[e] = zero_ss; nb_tp[e] = zero_ss; nb_rr[e] = zero_ss; nb_tr[e] = zero_ss;
			nb_rf[e] = zero_ss; nb_tf[e] = zero_ss; nb_re[e] = zero_ss;
		end
		nb_re[e] = '{t: open_header.stamp, s: open_header.stamp_sequence};
		if (nb_tr[e].t == 0) begin
			// echo of our last receive gives Tr, otherwise restart the round
			if (nb_rr[e].s == open_header.echo_sequence)
				nb_tr[e] = '{t: open_header.echo_stamp, s: open_header.echo_sequence};
			else
				nb_rr[e] = nb_re[e];
		end
		if (reply_found && reply_stamp.t != 0) begin
			nb_rf[e] = reply_stamp;
			// highest matching ring slot wins
			for (int i = 0; i < RING_SLOTS; i++)
				if (tx_stamps[i].s == reply_stamp.s)
					nb_tf[e] = tx_stamps[i];
		end
		if (nb_tr[e].t != 0 && nb_rf[e].t != 0 && nb_tf[e].t != 0) begin
			r.status = ds_twr_distance(e, range_cm) ? STS_ZERO : STS_DIST;
			r.distance_cm = range_cm;
			nb_rp[e] = nb_rf[e];
			nb_tp[e] = nb_tf[e];
			nb_rr[e] = nb_re[e];
			nb_rf[e] = zero_ss;
			nb_tf[e] = zero_ss;
			nb_tr[e] = zero_ss;
		end else if (nb_rf[e].t != 0 && nb_tf[e].t != 0) begin
			// rotate without a distance; only the stamps are cleared
			nb_rp[e] = nb_rf[e];
			nb_tp[e] = nb_tf[e];
			nb_rr[e] = nb_re[e];
			nb_rf[e].t = '0;
			nb_tf[e].t = '0;
			nb_tr[e].t = '0;
		end
		r.table_slot = 4'(e);
		return r;
	endfunction

	// applies one accepted item to the predictor
	function automatic void predict_ranging(input msg_item_t it);
		case (it.command)
			CMD_HEADER: begin
				msg_open = 1'b1;
				open_header = it;
				reply_found = 1'b0;
				reply_stamp = '{t: '0, s: '0};
				if (it.last_of_message)
					expected_ranges.push_back(close_open_message());
			end
			CMD_BODY: begin
				if (msg_open) begin
					// only the first unit addressed to us counts
					if (!reply_found && it.peer_address == own_address) begin
						reply_found = 1'b1;
						reply_stamp = '{t: it.stamp, s: it.stamp_sequence};
					end
					if (it.last_of_message)
						expected_ranges.push_back(close_open_message());
				end
			end
			CMD_TX_DONE: begin
				tx_pos = (tx_pos + 1) % RING_SLOTS;
				tx_stamps[tx_pos] = '{t: it.stamp, s: it.stamp_sequence};
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// channel drivers and result checker
	// ---------------------------------------------------------------

	// sends one item; called and returns at a rising edge, valid stays up
	task automatic send_item(input msg_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			msg_ch.valid <= 1'b0;
			@(posedge clk);
		end
		msg_ch.valid           <= 1'b1;
		msg_ch.command         <= it.command;
		msg_ch.last_of_message <= it.last_of_message;
		msg_ch.peer_address    <= it.peer_address;
		msg_ch.stamp           <= it.stamp;
		msg_ch.stamp_sequence  <= it.stamp_sequence;
		msg_ch.echo_sequence   <= it.echo_sequence;
		msg_ch.echo_stamp      <= it.echo_stamp;
		@(posedge clk);
		while (!msg_ch.ready)
			@(posedge clk);
		predict_ranging(it);
	endtask

	// writes my_address while the block is idle
	task automatic write_own_address(input logic [15:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		own_address = value;
	endtask

	// drops valid and waits for every owed result, then for trailing work
	task automatic wait_idle();
		msg_ch.valid <= 1'b0;
		while (expected_ranges.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result side ready: random idling, or a long counted hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (take_hold_cycles > 0) begin
			res_ch.ready <= 1'b0;
			take_hold_cycles <= take_hold_cycles - 1;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= take_idle_pct);
		end
	end

	// compares each taken result item with the oldest expectation
	always @(posedge clk) begin
		range_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_ranges.size() == 0) begin
				report_mismatch($sformatf("unexpected result status %0d slot %0d",
					res_ch.status, res_ch.table_slot));
			end else begin
				want = expected_ranges.pop_front();
				if (res_ch.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						res_ch.status, want.status));
				if (res_ch.distance_cm !== want.distance_cm)
					report_mismatch($sformatf("distance_cm %0d, want %0d",
						res_ch.distance_cm, want.distance_cm));
				if (res_ch.table_slot !== want.table_slot)
					report_mismatch($sformatf("table_slot %0d, want %0d",
						res_ch.table_slot, want.table_slot));
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------
	logic [SB-1:0] air_time;      // running local clock for plausible stamps
	logic [15:0]   our_tx_seq;
	logic [15:0]   peer_addr [16];
	logic [15:0]   peer_seq [16];
	logic [SB-1:0] peer_tx_stamp [16];

	function automatic msg_item_t make_item(input logic [1:0] cmd, input logic last,
		input logic [15:0] addr, input logic [SB-1:0] st, input logic [15:0] seq,
		input logic [15:0] eseq, input logic [SB-1:0] est);
		msg_item_t it;
		it = '{command: cmd, last_of_message: last, peer_address: addr, stamp: st,
			stamp_sequence: seq, echo_sequence: eseq, echo_stamp: est};
		return it;
	endfunction

	function automatic logic [SB-1:0] rand_stamp();
		return {8'($urandom_range(255)), $urandom()};
	endfunction

	function automatic logic [SB-1:0] tick();
		air_time = air_time + SB'($urandom_range(1, 4000));
		return air_time;
	endfunction

	// fully random item, unused command included
	task automatic send_noise();
		send_item(make_item(2'($urandom_range(3)), 1'($urandom), 16'($urandom),
			rand_stamp(), 16'($urandom), 16'($urandom), rand_stamp()));
	endtask

	// one well-formed round with peer number p: our transmits, then its message
	task automatic run_exchange(input int p);
		int n_tx, n_body, us_at;
		logic [15:0] eseq;
		n_tx = $urandom_range(2);
		for (int i = 0; i < n_tx; i++) begin
			our_tx_seq++;
			send_item(make_item(CMD_TX_DONE, 1'($urandom), 16'($urandom), tick(),
				our_tx_seq, 16'($urandom), rand_stamp()));
		end
		// mostly echo the previous message, sometimes a stale sequence
		eseq = ($urandom_range(9) != 0) ? peer_seq[p] : 16'($urandom);
		peer_seq[p]++;
		n_body = $urandom_range(3);
		us_at = $urandom_range(n_body);
		send_item(make_item(CMD_HEADER, n_body == 0, peer_addr[p], tick(), peer_seq[p],
			eseq, peer_tx_stamp[p]));
		peer_tx_stamp[p] = tick();
		for (int i = 1; i <= n_body; i++) begin
			// an occasional broken message is left open for the next header
			if (i == n_body && $urandom_range(19) == 0)
				break;
			if (i == us_at || $urandom_range(5) == 0)
				send_item(make_item(CMD_BODY, i == n_body, own_address, tick(),
					our_tx_seq - 16'($urandom_range(1)), 16'($urandom), rand_stamp()));
			else
				send_item(make_item(CMD_BODY, i == n_body, 16'($urandom), rand_stamp(),
					16'($urandom), 16'($urandom), rand_stamp()));
		end
	endtask

	// mostly ranging rounds over a few peers, some noise
	task automatic run_random_traffic(input int n_rounds, input int n_peers);
		for (int k = 0; k < n_rounds; k++) begin
			if ($urandom_range(9) == 0)
				send_noise();
			else
				run_exchange($urandom_range(n_peers - 1));
		end
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// extremes, every command and each corner of message handling
	task automatic test_directed();
		logic [SB-1:0] x;
		x = 40'h12_3456_789A;
		write_own_address(16'h0000);
		send_item(make_item(CMD_TX_DONE, 1'b0, 16'h0000, {SB{1'b1}}, 16'hFFFF, 16'h0, '0));
		send_item(make_item(CMD_TX_DONE, 1'b1, 16'hFFFF, x, 16'h0007, 16'hFFFF, '1));
		// body unit with no open message is dropped
		send_item(make_item(CMD_BODY, 1'b1, 16'h0000, x, 16'h0007, 16'h0, '0));
		// unused command is dropped
		send_item(make_item(2'd3, 1'b1, 16'hFFFF, '1, 16'hFFFF, 16'hFFFF, '1));
		// header alone closes a message at the lowest peer address
		send_item(make_item(CMD_HEADER, 1'b1, 16'h0000, '0, 16'h0000, 16'h0000, '0));
		send_item(make_item(CMD_HEADER, 1'b1, 16'hFFFF, '1, 16'hFFFF, 16'hFFFF, '1));
		// header while open drops the first message
		send_item(make_item(CMD_HEADER, 1'b0, 16'h0101, x, 16'h0001, 16'h0002, x));
		send_item(make_item(CMD_HEADER, 1'b0, 16'h0202, x, 16'h0001, 16'h0002, x));
		// zero reply stamp does not set Rf, and only the first unit to us counts
		send_item(make_item(CMD_BODY, 1'b0, 16'h0000, '0, 16'h0007, 16'h0, '0));
		send_item(make_item(CMD_BODY, 1'b0, 16'h0000, x, 16'h0007, 16'h0, '0));
		send_item(make_item(CMD_BODY, 1'b1, 16'h0303, x, 16'h0007, 16'h0, '0));
		// equal stamps everywhere: first round rotates, second hits a zero divisor
		send_item(make_item(CMD_HEADER, 1'b0, 16'h0404, x, 16'h00A0, 16'h0055, x));
		send_item(make_item(CMD_BODY, 1'b1, 16'h0000, x, 16'h0007, 16'h0, '0));
		send_item(make_item(CMD_HEADER, 1'b0, 16'h0404, x, 16'h00A1, 16'h00A0, x));
		send_item(make_item(CMD_BODY, 1'b1, 16'h0000, x, 16'h0007, 16'h0, '0));
		// full-range stamps that wrap, towards a saturated distance
		send_item(make_item(CMD_TX_DONE, 1'b0, 16'h0, 40'h00_0000_0010, 16'h0009, 16'h0, '0));
		send_item(make_item(CMD_HEADER, 1'b0, 16'h0505, '1, 16'h0010, 16'h0033, '1));
		send_item(make_item(CMD_BODY, 1'b1, 16'h0000, 40'h80_0000_0000, 16'h0009, 16'h0, '0));
		send_item(make_item(CMD_TX_DONE, 1'b0, 16'h0, 40'h7F_FFFF_FFFF, 16'h000A, 16'h0, '0));
		send_item(make_item(CMD_HEADER, 1'b0, 16'h0505, 40'h00_0000_0001, 16'h0011,
			16'h0010, 40'hFF_0000_0000));
		send_item(make_item(CMD_BODY, 1'b1, 16'h0000, 40'h00_0000_0005, 16'h000A, 16'h0, '0));
		wait_idle();
	endtask

	// long hold-off on the result side while items keep coming
	task automatic test_result_backpressure();
		take_hold_cycles = 1500;
		run_random_traffic(60, 10);
	endtask

	// as many new peers as the table holds, on top of the entries already in it
	task automatic test_table_full();
		for (int i = 0; i < 16; i++)
			peer_addr[i] = 16'h8000 + 16'(i * 37);
		run_random_traffic(80, 16);
	endtask

	// ---------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------
	initial begin
		msg_ch.valid = 1'b0;
		msg_ch.command = CMD_HEADER;
		msg_ch.last_of_message = 1'b0;
		msg_ch.peer_address = '0;
		msg_ch.stamp = '0;
		msg_ch.stamp_sequence = '0;
		msg_ch.echo_sequence = '0;
		msg_ch.echo_stamp = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		res_ch.ready = 1'b0;
		send_idle_pct = 0;
		take_idle_pct = 0;
		take_hold_cycles = 0;
		error_count = 0;
		own_address = '0;
		tx_pos = 0;
		msg_open = 1'b0;
		reply_found = 1'b0;
		for (int i = 0; i < ENTRIES; i++)
			nb_valid[i] = 1'b0;
		for (int i = 0; i < RING_SLOTS; i++)
			tx_stamps[i] = '{t: '0, s: '0};
		air_time = rand_stamp();
		our_tx_seq = 16'($urandom);
		// small peer pool keeps the table below full until the last test
		for (int i = 0; i < 16; i++) begin
			peer_addr[i] = 16'h1000 + 16'($urandom_range(255)) * 16 + 16'(i);
			peer_seq[i] = 16'($urandom);
			peer_tx_stamp[i] = rand_stamp();
		end

		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();

		// sender idles little, receiver a lot
		send_idle_pct = 19;
		take_idle_pct = 83;
		write_own_address(16'hFFFF);
		run_random_traffic(90, 8);
		wait_idle();

		// receiver idles little, sender a lot
		send_idle_pct = 83;
		take_idle_pct = 19;
		write_own_address(16'($urandom));
		run_random_traffic(90, 8);
		wait_idle();

		// no idling on either side
		send_idle_pct = 0;
		take_idle_pct = 0;
		write_own_address(16'h0000);
		run_random_traffic(40, 8);
		test_result_backpressure();
		wait_idle();

		write_own_address(16'h5AA5);
		test_table_full();
		wait_idle();

		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// run limit
	initial begin
		#50_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
